[hdl/spt_pkg.sv]
package spt_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_READ   = 2'd2,
    REQ_NONE   = 2'd3
  } spt_op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } spt_status_t;

  typedef enum logic {
    S_IDLE,
    S_WORK
  } spt_state_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] key;
    logic signed [31:0] ident;
    logic [5:0]         position;
  } spt_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [6:0]         removed_count;
    logic [6:0]         entry_count;
    logic signed [31:0] read_key;
    logic signed [31:0] read_ident;
  } spt_rsp_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic               ins;
    logic               del;
    logic signed [31:0] key;
    logic signed [31:0] ident;
    logic [5:0]         pos;
    logic [CNT_W-1:0]   count;
  } spt_ctrl_t;

endpackage

[hdl/spt_cell.sv]
module spt_cell
  import spt_pkg::*;
(
  input  logic               clk,
  input  logic [IDX_W-1:0]   index,
  input  spt_ctrl_t          ctrl,
  input  logic               ge_left,
  input  logic signed [31:0] key_left,
  input  logic signed [31:0] ident_left,
  input  logic signed [31:0] key_right,
  input  logic signed [31:0] ident_right,
  output logic               ge,
  output logic               hit,
  output logic signed [31:0] key,
  output logic signed [31:0] ident,
  output logic [63:0]        rd_word
);

  logic occupied;
  logic eq;

  always_comb begin
    occupied = CNT_W'(index) < ctrl.count;
    // empty cells count as greater so the chain stays monotone
    ge       = !occupied || !(key < ctrl.key);
    eq       = occupied && (key == ctrl.key);
    hit      = ge && !ge_left && eq;
    rd_word  = (CMP_W'(index) == CMP_W'(ctrl.pos)) ? {key, ident} : 64'd0;
  end

  always_ff @(posedge clk) begin
    if (ctrl.ins && ge) begin
      if (ge_left) begin
        key   <= key_left;
        ident <= ident_left;
      end else begin
        key   <= ctrl.key;
        ident <= ctrl.ident;
      end
    end else if (ctrl.del && ge) begin
      // close the gap left by the first matching entry
      key   <= key_right;
      ident <= ident_right;
    end
  end

endmodule

[hdl/sorted_priority_table.sv]
// Sorted priority table: up to DEPTH records (signed key, identifier) held
// in ascending key order in a chain of cells, one record per cell.
// Input channel in_valid/in_stall/in_data carries one request: insert,
// remove all entries with a key, or read the entry at a position.
// Output channel out_valid/out_stall/out_data carries one response per
// request with status, removed count, entry count and the read record.
// A request is held in the block in its work state; its response is
// registered when the request leaves that state. A remove deletes one
// matching entry per cycle, every cell at or beyond the match taking
// its right neighbour, until no entry matches.
// On insertion every cell compares its key with the new one and either
// keeps, takes the new record or takes its left neighbour.
// Reset empties the table; cell contents are left as they are.
// While the response register is stalled the block holds the current
// request in its work state and keeps in_stall high.
module sorted_priority_table
  import spt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  spt_req_t in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output spt_rsp_t out_data
);

  spt_state_t       state, state_next;
  spt_req_t         req;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] removed;

  spt_ctrl_t          ctrl;
  logic [DEPTH-1:0]   ge_vec;
  logic [DEPTH-1:0]   hit_vec;
  logic signed [31:0] cell_key   [DEPTH];
  logic signed [31:0] cell_ident [DEPTH];
  logic [63:0]        cell_rd    [DEPTH];
  logic [63:0]        rd_bus;

  logic is_ins, is_rem, is_read;
  logic full, pos_ok, match_any, out_free;
  logic del_step, commit, ins_step;
  logic [CNT_W-1:0] count_after;
  spt_rsp_t rsp;

  always_comb begin
    is_ins    = spt_op_t'(req.req_type) == REQ_INSERT;
    is_rem    = spt_op_t'(req.req_type) == REQ_REMOVE;
    is_read   = spt_op_t'(req.req_type) == REQ_READ;
    full      = count == CNT_W'(DEPTH);
    pos_ok    = CMP_W'(req.position) < CMP_W'(count);
    match_any = |hit_vec;
    out_free  = !out_valid || !out_stall;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_WORK;
      S_WORK: if (commit) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall = state != S_IDLE;
    del_step = (state == S_WORK) && is_rem && match_any;
    commit   = (state == S_WORK) && !del_step && out_free;
    ins_step = commit && is_ins && !full;
  end

  always_comb begin
    ctrl.ins   = ins_step;
    ctrl.del   = del_step;
    ctrl.key   = req.key;
    ctrl.ident = req.ident;
    ctrl.pos   = req.position;
    ctrl.count = count;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic               gl;
    logic signed [31:0] kl, il, kr, ir;
    if (i == 0) begin : g_first
      assign gl = 1'b0;
      assign kl = req.key;
      assign il = req.ident;
    end else begin : g_mid
      assign gl = ge_vec[i-1];
      assign kl = cell_key[i-1];
      assign il = cell_ident[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign kr = cell_key[i];
      assign ir = cell_ident[i];
    end else begin : g_inner
      assign kr = cell_key[i+1];
      assign ir = cell_ident[i+1];
    end
    spt_cell u_cell (
      .clk         (clk),
      .index       (IDX_W'(i)),
      .ctrl        (ctrl),
      .ge_left     (gl),
      .key_left    (kl),
      .ident_left  (il),
      .key_right   (kr),
      .ident_right (ir),
      .ge          (ge_vec[i]),
      .hit         (hit_vec[i]),
      .key         (cell_key[i]),
      .ident       (cell_ident[i]),
      .rd_word     (cell_rd[i])
    );
  end

  always_comb begin
    rd_bus = 64'd0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_bus = rd_bus | cell_rd[i];
    end
  end

  always_comb begin
    count_after       = ins_step ? count + CNT_W'(1) : count;
    rsp.status        = ST_OK;
    rsp.removed_count = 7'(removed);
    rsp.entry_count   = 7'(count_after);
    rsp.read_key      = '0;
    rsp.read_ident    = '0;
    if (is_ins && full) begin
      rsp.status = ST_FULL;
    end else if (is_read) begin
      if (pos_ok) begin
        rsp.read_key   = rd_bus[63:32];
        rsp.read_ident = rd_bus[31:0];
      end else begin
        rsp.status = ST_RANGE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      removed   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && in_valid) begin
        req     <= in_data;
        removed <= '0;
      end
      if (del_step) begin
        count   <= count - CNT_W'(1);
        removed <= removed + CNT_W'(1);
      end else if (ins_step) begin
        count <= count + CNT_W'(1);
      end
      if (commit) begin
        out_valid <= 1'b1;
        out_data  <= rsp;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count beyond table depth");

  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    $onehot0(hit_vec))
    else $error("more than one cell claims the first match");

  a_del_shrinks: assert property (@(posedge clk) disable iff (rst)
    del_step |=> count == $past(count) - CNT_W'(1))
    else $error("remove step did not drop one entry");

  a_ins_grows: assert property (@(posedge clk) disable iff (rst)
    ins_step |=> count == $past(count) + CNT_W'(1) && out_valid)
    else $error("insert did not add one entry with a response");

endmodule
